// ----- rtl/core/mcdm_pkg.sv -----
// Shared types and constants for the multi-channel deadline monitor.
// Used by mcdm_ctrl, mcdm_dp and the top level; no dependencies.
package mcdm_pkg;

  localparam int DEF_CHANNELS = 64;
  localparam int MASK_W = 64;
  localparam int CIU_W = 7;
  localparam int CH_FIELD_W = 6;
  localparam int TO_W = 32;
  localparam int CNT_W = 32;
  localparam logic [TO_W-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_START   = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_RX_IND  = 3'd3,
    REQ_HANDLE  = 3'd4,
    REQ_QUERY   = 3'd5,
    REQ_SET_TO  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    TS_STOPPED = 2'd0,
    TS_RUNNING = 2'd1,
    TS_EXPIRED = 2'd2,
    TS_ERROR   = 2'd3
  } tstate_t;

  localparam logic [1:0] CFG_CIU = 2'd0;
  localparam logic [1:0] CFG_RXM = 2'd1;
  localparam logic [1:0] CFG_GRP = 2'd2;

  localparam logic [2:0] ACT_MAX = 3'd3;

  typedef struct packed {
    logic load;
    logic fetch;
    logic exec;
    logic sweep_run;
    logic post;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic sweep_done;
  } sts_t;

endpackage

// ----- rtl/core/mcdm_ctrl.sv -----
// Request sequencer for the deadline monitor: handshakes and command strobes.
// Depends on mcdm_pkg; drives mcdm_dp through cmd_t, reads sts_t.
module mcdm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mcdm_pkg::sts_t sts,
  output mcdm_pkg::cmd_t cmd
);
  import mcdm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SWEEP = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.is_tick ? S_SWEEP : S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (!sts.sweep_done) begin
          cmd.sweep_run = 1'b1;
        end else if (slot_free) begin
          cmd.post  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.exec || cmd.post) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec || cmd.post) |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");
  a_exec_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> ($past(state_r) == S_FETCH || $past(state_r) == S_EXEC))
    else $error("exec entered without fetch");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("result beat dropped before accept");
`endif

endmodule

// ----- rtl/core/mcdm_dp.sv -----
// Datapath for the deadline monitor: config registers, channel table memory,
// sweep pipeline and result register. Depends on mcdm_pkg; driven by mcdm_ctrl.
module mcdm_dp #(
  parameter int CHANNELS = mcdm_pkg::DEF_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [mcdm_pkg::MASK_W-1:0]       cfg_data,
  input  logic [2:0]                        in_req_type,
  input  logic [mcdm_pkg::CH_FIELD_W-1:0]   in_channel,
  input  logic [mcdm_pkg::TO_W-1:0]         in_timeout_value,
  input  logic                              in_monitor_enabled,
  input  logic [2:0]                        in_timeout_action,
  input  logic                              in_hook_present,
  input  logic                              in_default_present,
  input  mcdm_pkg::cmd_t                    cmd,
  output mcdm_pkg::sts_t                    sts,
  output logic                              out_status,
  output logic [1:0]                        out_channel_state,
  output logic                              out_timeout_processed,
  output logic [mcdm_pkg::CNT_W-1:0]        out_expiry_total,
  output logic                              out_call_error_hook,
  output logic                              out_apply_default,
  output logic [mcdm_pkg::CIU_W-1:0]        out_newly_expired
);
  import mcdm_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SWEEP_MAX = (CHANNELS < MASK_W) ? CHANNELS : MASK_W;

  typedef struct packed {
    logic [TO_W-1:0]  remaining;
    logic [1:0]       tstate;
    logic             processed;
    logic [CNT_W-1:0] expiry;
    logic [TO_W-1:0]  timeout;
  } row_t;

  logic [CIU_W-1:0]  ciu_r;
  logic [MASK_W-1:0] rxm_r;
  logic [MASK_W-1:0] grp_r;

  logic [2:0]            req_r;
  logic [CH_FIELD_W-1:0] ch_r;
  logic [TO_W-1:0]       tv_r;
  logic                  mon_r;
  logic [2:0]            act_r;
  logic                  hook_r;
  logic                  dflt_r;

  row_t                mem [CHANNELS];
  logic [CHANNELS-1:0] valid_r;
  row_t                rd_row_r;
  logic                rd_vld_r;
  row_t                cur;

  logic [CIU_W-1:0] idx_r;
  logic [CIU_W-1:0] p_idx_r;
  logic             p_vld_r;
  logic [CIU_W-1:0] cnt_r;
  logic [CIU_W-1:0] lim;
  logic             more;

  logic [CH_W+CIU_W-1:0] ch_ext;
  logic [CH_W+CIU_W-1:0] idx_ext;
  logic [CH_W+CIU_W-1:0] pidx_ext;
  logic [CH_W-1:0]       ch_addr;
  logic                  ch_oob;

  logic            rd_en;
  logic [CH_W-1:0] rd_addr;
  logic            we;
  logic [CH_W-1:0] wr_addr;
  row_t            wr_row;

  row_t            ex_row;
  logic            ex_wr;
  logic            ex_status;
  logic            ex_hook;
  logic            ex_dflt;
  logic [TO_W-1:0] rx_to;

  row_t sw_row;
  logic sw_hit;
  logic sw_exp;

  assign ch_ext   = {{(CH_W+1){1'b0}}, ch_r};
  assign idx_ext  = {{CH_W{1'b0}}, idx_r};
  assign pidx_ext = {{CH_W{1'b0}}, p_idx_r};
  assign ch_addr  = ch_ext[CH_W-1:0];
  assign ch_oob   = (32'(ch_r) >= CHANNELS);

  assign lim  = (ciu_r > CIU_W'(SWEEP_MAX)) ? CIU_W'(SWEEP_MAX) : ciu_r;
  assign more = (idx_r < lim);

  assign sts.is_tick    = (in_req_type == REQ_TICK);
  assign sts.sweep_done = !more && !p_vld_r;

  assign cur = rd_vld_r ? rd_row_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ciu_r <= '0;
      rxm_r <= '0;
      grp_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CIU: ciu_r <= cfg_data[CIU_W-1:0];
        CFG_RXM: rxm_r <= cfg_data;
        CFG_GRP: grp_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      ch_r   <= in_channel;
      tv_r   <= in_timeout_value;
      mon_r  <= in_monitor_enabled;
      act_r  <= in_timeout_action;
      hook_r <= in_hook_present;
      dflt_r <= in_default_present;
    end
  end

  // request execution on the fetched row
  always_comb begin
    ex_row    = cur;
    ex_wr     = 1'b0;
    ex_status = 1'b0;
    ex_hook   = 1'b0;
    ex_dflt   = 1'b0;
    rx_to     = (tv_r == '0) ? cur.timeout : tv_r;
    case (req_r)
      REQ_START: begin
        if (tv_r == ALL_ONES) begin
          ex_status = 1'b1;
        end else if (tv_r != '0) begin
          ex_row.remaining = tv_r;
          ex_row.tstate    = TS_RUNNING;
          ex_row.processed = 1'b0;
          ex_wr            = 1'b1;
        end else begin
          ex_row.remaining = '0;
          ex_row.tstate    = TS_STOPPED;
          ex_wr            = 1'b1;
        end
      end
      REQ_STOP: begin
        ex_row.remaining = '0;
        ex_row.tstate    = TS_STOPPED;
        ex_row.processed = 1'b0;
        ex_wr            = 1'b1;
      end
      REQ_RX_IND: begin
        if (!mon_r) begin
          ex_status = 1'b1;
        end else begin
          if (rx_to == ALL_ONES) begin
            ex_status = 1'b1;
          end else if (rx_to != '0) begin
            ex_row.remaining = rx_to;
            ex_row.tstate    = TS_RUNNING;
            ex_row.processed = 1'b0;
          end else begin
            ex_row.remaining = '0;
            ex_row.tstate    = TS_STOPPED;
          end
          if (ex_row.tstate == TS_EXPIRED || ex_row.tstate == TS_ERROR) begin
            ex_row.tstate    = TS_RUNNING;
            ex_row.processed = 1'b0;
          end
          ex_wr = 1'b1;
        end
      end
      REQ_HANDLE: begin
        if (act_r > ACT_MAX) begin
          ex_status = 1'b1;
        end else begin
          ex_row.processed = 1'b1;
          ex_hook          = act_r[0] && hook_r;
          ex_dflt          = act_r[1] && dflt_r;
          ex_wr            = 1'b1;
        end
      end
      REQ_QUERY: ;
      REQ_SET_TO: begin
        ex_row.timeout = tv_r;
        ex_wr          = 1'b1;
      end
      default: ex_status = 1'b1;
    endcase
  end

  // sweep stage on the row read in the previous cycle
  always_comb begin
    sw_row = cur;
    sw_hit = rxm_r[p_idx_r[CH_FIELD_W-1:0]] && grp_r[p_idx_r[CH_FIELD_W-1:0]] &&
             (cur.timeout != '0) && (cur.tstate == TS_RUNNING);
    sw_exp = sw_hit && (cur.remaining == '0);
    if (sw_hit) begin
      if (cur.remaining != '0) begin
        sw_row.remaining = cur.remaining - TO_W'(1);
      end else begin
        sw_row.tstate = TS_EXPIRED;
        sw_row.expiry = cur.expiry + CNT_W'(1);
      end
    end
  end

  assign rd_en   = (cmd.fetch && !ch_oob) || (cmd.sweep_run && more);
  assign rd_addr = cmd.fetch ? ch_addr : idx_ext[CH_W-1:0];
  assign we      = (cmd.exec && ex_wr && !ch_oob) || (p_vld_r && sw_hit);
  assign wr_addr = p_vld_r ? pidx_ext[CH_W-1:0] : ch_addr;
  assign wr_row  = p_vld_r ? sw_row : ex_row;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      p_idx_r <= '0;
      p_vld_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cmd.load) begin
        idx_r <= '0;
        cnt_r <= '0;
      end else if (cmd.sweep_run && more) begin
        idx_r   <= idx_r + CIU_W'(1);
        p_idx_r <= idx_r;
      end
      p_vld_r <= cmd.sweep_run && more;
      if (p_vld_r && sw_exp) begin
        cnt_r <= cnt_r + CIU_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_status            <= 1'b0;
      out_channel_state     <= TS_STOPPED;
      out_timeout_processed <= 1'b0;
      out_expiry_total      <= '0;
      out_call_error_hook   <= 1'b0;
      out_apply_default     <= 1'b0;
      out_newly_expired     <= cnt_r;
    end else if (cmd.exec) begin
      out_newly_expired <= '0;
      if (ch_oob) begin
        out_status            <= 1'b1;
        out_channel_state     <= TS_ERROR;
        out_timeout_processed <= 1'b0;
        out_expiry_total      <= '0;
        out_call_error_hook   <= 1'b0;
        out_apply_default     <= 1'b0;
      end else begin
        out_status            <= ex_status;
        out_channel_state     <= ex_row.tstate;
        out_timeout_processed <= ex_row.processed;
        out_expiry_total      <= ex_row.expiry;
        out_call_error_hook   <= ex_hook;
        out_apply_default     <= ex_dflt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_exec_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.exec && p_vld_r))
    else $error("request write collides with sweep write");
  a_sweep_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (32'(p_idx_r) < SWEEP_MAX))
    else $error("sweep index beyond table");
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cnt_r) <= SWEEP_MAX) && (cnt_r <= idx_r))
    else $error("expiry count exceeds swept channels");
`endif

endmodule

// ----- rtl/core/multi_channel_deadline_monitor.sv -----
// Top level of the multi-channel receive deadline monitor.
// Depends on mcdm_pkg, mcdm_ctrl and mcdm_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | in_req_type .. in_default_present
//  out     | out_valid/out_ready  | out_status .. out_newly_expired
//
// A non-tick request goes through accept, table read, then execute and write
// back. A tick sweeps min(channels_in_use, CHANNELS, 64) channels, one channel
// per cycle through one read and one write port of the table.
// Reset clears config and per-entry valid bits at once; no clearing pass.
// A result beat waits in the output register; the next beat is accepted
// meanwhile and its execution holds until the output register frees up.
module multi_channel_deadline_monitor #(
  parameter int CHANNELS = mcdm_pkg::DEF_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [mcdm_pkg::MASK_W-1:0]      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_req_type,
  input  logic [mcdm_pkg::CH_FIELD_W-1:0]  in_channel,
  input  logic [mcdm_pkg::TO_W-1:0]        in_timeout_value,
  input  logic                             in_monitor_enabled,
  input  logic [2:0]                       in_timeout_action,
  input  logic                             in_hook_present,
  input  logic                             in_default_present,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic [1:0]                       out_channel_state,
  output logic                             out_timeout_processed,
  output logic [mcdm_pkg::CNT_W-1:0]       out_expiry_total,
  output logic                             out_call_error_hook,
  output logic                             out_apply_default,
  output logic [mcdm_pkg::CIU_W-1:0]       out_newly_expired
);
  import mcdm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mcdm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mcdm_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_req_type           (in_req_type),
    .in_channel            (in_channel),
    .in_timeout_value      (in_timeout_value),
    .in_monitor_enabled    (in_monitor_enabled),
    .in_timeout_action     (in_timeout_action),
    .in_hook_present       (in_hook_present),
    .in_default_present    (in_default_present),
    .cmd                   (cmd),
    .sts                   (sts),
    .out_status            (out_status),
    .out_channel_state     (out_channel_state),
    .out_timeout_processed (out_timeout_processed),
    .out_expiry_total      (out_expiry_total),
    .out_call_error_hook   (out_call_error_hook),
    .out_apply_default     (out_apply_default),
    .out_newly_expired     (out_newly_expired)
  );

endmodule

// ----- tb/multi_channel_deadline_monitor_tb.sv -----
// Self-checking testbench for multi_channel_deadline_monitor: directed request table,
// then random timer lifecycles under bursty input and stalling output, checked beat by beat.
// Depends on mcdm_pkg and the multi_channel_deadline_monitor RTL.
module multi_channel_deadline_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcdm_pkg::*;

  localparam int CHANNELS = DEF_CHANNELS;
  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] REQ_BAD = 3'd7;
  localparam logic [1:0] CFG_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  req;
    logic [5:0]  ch;
    logic [31:0] tv;
    logic        mon;
    logic [2:0]  act;
    logic        hook;
    logic        dflt;
  } beat_t;

  typedef struct packed {
    logic        status;
    tstate_t     state;
    logic        processed;
    logic [31:0] expiry;
    logic        hook;
    logic        dflt;
    logic [6:0]  newly;
  } reply_t;

  typedef struct packed {
    beat_t  b;
    logic   typed;
    reply_t r;
  } plan_row_t;

  localparam reply_t IDLE_REPLY  = '{1'b0, TS_STOPPED, 1'b0, 32'd0, 1'b0, 1'b0, 7'd0};
  localparam reply_t REJ_STOPPED = '{1'b1, TS_STOPPED, 1'b0, 32'd0, 1'b0, 1'b0, 7'd0};
  localparam reply_t OK_RUNNING  = '{1'b0, TS_RUNNING, 1'b0, 32'd0, 1'b0, 1'b0, 7'd0};
  localparam reply_t REJ_RUNNING = '{1'b1, TS_RUNNING, 1'b0, 32'd0, 1'b0, 1'b0, 7'd0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [5:0]  in_channel = '0;
  logic [31:0] in_timeout_value = '0;
  logic        in_monitor_enabled = 1'b0;
  logic [2:0]  in_timeout_action = '0;
  logic        in_hook_present = 1'b0;
  logic        in_default_present = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [1:0]  out_channel_state;
  logic        out_timeout_processed;
  logic [31:0] out_expiry_total;
  logic        out_call_error_hook;
  logic        out_apply_default;
  logic [6:0]  out_newly_expired;

  multi_channel_deadline_monitor #(.CHANNELS(CHANNELS)) DUT (.*);

  // timer table mirror
  logic [31:0] ticks_left [CHANNELS];
  tstate_t     tstate     [CHANNELS];
  logic [31:0] expiries   [CHANNELS];
  logic        processed  [CHANNELS];
  logic [31:0] reload_val [CHANNELS];
  logic [6:0]  sweep_len;
  logic [63:0] rx_chan_mask;
  logic [63:0] grp_mask;

  reply_t awaited_replies [$];
  int requests_sent = 0;
  int tick_count = 0;
  int expiry_seen = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rcv_cycle = 0;
  int cycle_count = 0;

  plan_row_t plan [27] = '{
    '{'{REQ_QUERY,  6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, IDLE_REPLY},
    '{'{REQ_QUERY,  6'd63, 32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, IDLE_REPLY},
    '{'{REQ_TICK,   6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, IDLE_REPLY},
    '{'{REQ_SET_TO, 6'd0,  32'd2,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, IDLE_REPLY},
    '{'{REQ_START,  6'd0,  32'd1,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, OK_RUNNING},
    '{'{REQ_START,  6'd0,  ALL_ONES,      1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, REJ_RUNNING},
    '{'{REQ_TICK,   6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_TICK,   6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_HANDLE, 6'd0,  32'd0,         1'b0, 3'd3, 1'b1, 1'b1}, 1'b0, IDLE_REPLY},
    '{'{REQ_HANDLE, 6'd0,  32'd0,         1'b0, 3'd7, 1'b1, 1'b1}, 1'b0, IDLE_REPLY},
    '{'{REQ_RX_IND, 6'd0,  32'd5,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_RX_IND, 6'd0,  ALL_ONES,      1'b1, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_TICK,   6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_RX_IND, 6'd0,  32'd0,         1'b1, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_RX_IND, 6'd1,  ALL_ONES,      1'b1, 3'd0, 1'b0, 1'b0}, 1'b1, REJ_STOPPED},
    '{'{REQ_SET_TO, 6'd2,  ALL_ONES,      1'b0, 3'd0, 1'b0, 1'b0}, 1'b1, IDLE_REPLY},
    '{'{REQ_RX_IND, 6'd2,  32'd0,         1'b1, 3'd0, 1'b0, 1'b0}, 1'b1, REJ_STOPPED},
    '{'{REQ_HANDLE, 6'd5,  32'd0,         1'b0, 3'd4, 1'b1, 1'b1}, 1'b1, REJ_STOPPED},
    '{'{REQ_START,  6'd3,  32'd5,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_HANDLE, 6'd3,  32'd0,         1'b0, 3'd2, 1'b1, 1'b1}, 1'b0, IDLE_REPLY},
    '{'{REQ_START,  6'd3,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_STOP,   6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_BAD,    6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_HANDLE, 6'd63, 32'd0,         1'b0, 3'd1, 1'b1, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_SET_TO, 6'd63, 32'hFFFF_FFFE, 1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_START,  6'd63, 32'hFFFF_FFFE, 1'b1, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY},
    '{'{REQ_TICK,   6'd0,  32'd0,         1'b0, 3'd0, 1'b0, 1'b0}, 1'b0, IDLE_REPLY}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic reload_timer(input int ch, input logic [31:0] t);
    if (t == ALL_ONES) return 1'b1;
    if (t != 32'd0) begin
      ticks_left[ch] = t;
      tstate[ch] = TS_RUNNING;
      processed[ch] = 1'b0;
    end else begin
      ticks_left[ch] = 32'd0;
      tstate[ch] = TS_STOPPED;
    end
    return 1'b0;
  endfunction

  function automatic reply_t deadline_step(input beat_t b);
    reply_t r;
    int n;
    int ch;
    logic [31:0] t;
    r = IDLE_REPLY;
    ch = int'(b.ch);
    if (b.req == REQ_TICK) begin
      n = (sweep_len > CHANNELS) ? CHANNELS : int'(sweep_len);
      for (int i = 0; i < n; i++) begin
        if (rx_chan_mask[i] && grp_mask[i] && reload_val[i] != 32'd0 &&
            tstate[i] == TS_RUNNING) begin
          if (ticks_left[i] != 32'd0) begin
            ticks_left[i] = ticks_left[i] - 32'd1;
          end else begin
            tstate[i] = TS_EXPIRED;
            expiries[i] = expiries[i] + 32'd1;
            r.newly = r.newly + 7'd1;
          end
        end
      end
      return r;
    end
    case (b.req)
      REQ_START: r.status = reload_timer(ch, b.tv);
      REQ_STOP: begin
        ticks_left[ch] = 32'd0;
        tstate[ch] = TS_STOPPED;
        processed[ch] = 1'b0;
      end
      REQ_RX_IND: begin
        if (!b.mon) begin
          r.status = 1'b1;
        end else begin
          t = (b.tv == 32'd0) ? reload_val[ch] : b.tv;
          r.status = reload_timer(ch, t);
          if (tstate[ch] == TS_EXPIRED || tstate[ch] == TS_ERROR) begin
            tstate[ch] = TS_RUNNING;
            processed[ch] = 1'b0;
          end
        end
      end
      REQ_HANDLE: begin
        if (b.act > ACT_MAX) begin
          r.status = 1'b1;
        end else begin
          processed[ch] = 1'b1;
          r.hook = b.act[0] & b.hook;
          r.dflt = b.act[1] & b.dflt;
        end
      end
      REQ_QUERY: ;
      REQ_SET_TO: reload_val[ch] = b.tv;
      default: r.status = 1'b1;
    endcase
    r.state = tstate[ch];
    r.processed = processed[ch];
    r.expiry = expiries[ch];
    return r;
  endfunction

  function automatic logic [5:0] pick_channel();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 6'($urandom_range(0, 7));
    if (p < 70) return 6'($urandom_range(56, 63));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [31:0] pick_timeout();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 32'($urandom_range(1, 4));
    if (p < 65) return 32'd0;
    if (p < 73) return ALL_ONES;
    if (p < 78) return 32'hFFFF_FFFE;
    return 32'($urandom);
  endfunction

  function automatic beat_t random_request();
    beat_t b;
    int p;
    b.ch = pick_channel();
    b.tv = pick_timeout();
    b.mon = ($urandom_range(0, 99) < 85);
    b.act = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
    b.hook = 1'($urandom);
    b.dflt = 1'($urandom);
    p = $urandom_range(0, 99);
    if (p < 28) b.req = REQ_TICK;
    else if (p < 40) b.req = REQ_START;
    else if (p < 47) b.req = REQ_STOP;
    else if (p < 62) b.req = REQ_RX_IND;
    else if (p < 74) b.req = REQ_HANDLE;
    else if (p < 82) b.req = REQ_QUERY;
    else if (p < 97) b.req = REQ_SET_TO;
    else b.req = REQ_BAD;
    return b;
  endfunction

  task automatic issue(input beat_t b, input logic typed, input reply_t fixed);
    reply_t r;
    in_req_type <= b.req;
    in_channel <= b.ch;
    in_timeout_value <= b.tv;
    in_monitor_enabled <= b.mon;
    in_timeout_action <= b.act;
    in_hook_present <= b.hook;
    in_default_present <= b.dflt;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = deadline_step(b);
    expiry_seen += int'(r.newly);
    awaited_replies.push_back(typed ? fixed : r);
    requests_sent++;
    if (b.req == REQ_TICK) tick_count++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                 : $urandom_range(1, 20);
      end else begin
        burst_left--;
      end
    end
  endtask

  // set, start, tick past the deadline, handle it, then rearm by rx
  task automatic run_lifecycle();
    beat_t b;
    int t;
    b = random_request();
    b.ch = pick_channel();
    t = $urandom_range(1, 3);
    b.req = REQ_SET_TO;
    b.tv = t;
    issue(b, 1'b0, IDLE_REPLY);
    b.req = REQ_START;
    issue(b, 1'b0, IDLE_REPLY);
    b.req = REQ_TICK;
    repeat (t + $urandom_range(1, 3)) issue(b, 1'b0, IDLE_REPLY);
    b.req = REQ_HANDLE;
    b.act = 3'($urandom_range(0, 3));
    issue(b, 1'b0, IDLE_REPLY);
    b.req = REQ_RX_IND;
    b.mon = 1'b1;
    b.tv = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(1, 4));
    issue(b, 1'b0, IDLE_REPLY);
  endtask

  task automatic run_random(input int n);
    int goal;
    goal = requests_sent + n;
    while (requests_sent < goal) begin
      if ($urandom_range(0, 99) < 40) run_lifecycle();
      else issue(random_request(), 1'b0, IDLE_REPLY);
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CIU: sweep_len = data[6:0];
      CFG_RXM: rx_chan_mask = data;
      CFG_GRP: grp_mask = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 30)
        $display("%0t ns: %s expected %0h actual %0h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_replies
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 30)
          $display("%0t ns: beat with no reply pending, expected none actual status %0h",
                   $realtime, out_status);
      end else begin
        want = awaited_replies.pop_front();
        cmp_field("status", 32'(want.status), 32'(out_status));
        cmp_field("channel_state", 32'(want.state), 32'(out_channel_state));
        cmp_field("timeout_processed", 32'(want.processed), 32'(out_timeout_processed));
        cmp_field("expiry_total", want.expiry, out_expiry_total);
        cmp_field("call_error_hook", 32'(want.hook), 32'(out_call_error_hook));
        cmp_field("apply_default", 32'(want.dflt), 32'(out_apply_default));
        cmp_field("newly_expired", 32'(want.newly), 32'(out_newly_expired));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      rcv_cycle <= 0;
    end else begin
      rcv_cycle <= rcv_cycle + 1;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        case (rcv_cycle[9:8])
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 99) < 70);
          2'd2: out_ready <= (rcv_cycle % 5 != 0);
          default: out_ready <= ($urandom_range(0, 99) < 30);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d replies pending",
               cycle_count, awaited_replies.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      ticks_left[i] = '0;
      tstate[i] = TS_STOPPED;
      expiries[i] = '0;
      processed[i] = 1'b0;
      reload_val[i] = '0;
    end
    sweep_len = '0;
    rx_chan_mask = '0;
    grp_mask = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(CFG_CIU, 64'(CHANNELS));
    write_reg(CFG_RXM, '1);
    write_reg(CFG_GRP, '1);
    foreach (plan[k]) issue(plan[k].b, plan[k].typed, plan[k].r);
    drain_replies();

    run_random(300);
    // stall the output while the input keeps offering beats
    hold_requests <= hold_requests + 1;
    no_gaps = 1'b1;
    repeat (40) issue(random_request(), 1'b0, IDLE_REPLY);
    no_gaps = 1'b0;
    run_random(100);
    drain_replies();
    run_random(100);

    drain_replies();
    write_reg(CFG_CIU, '1);
    write_reg(CFG_RXM, {$urandom, $urandom});
    write_reg(CFG_GRP, {$urandom, $urandom});
    run_random(350);

    drain_replies();
    write_reg(CFG_CIU, 64'd0);
    write_reg(CFG_RXM, 64'd0);
    write_reg(CFG_GRP, 64'd0);
    run_random(120);

    drain_replies();
    write_reg(CFG_CIU, 64'($urandom_range(8, 63)));
    write_reg(CFG_RXM, {$urandom, $urandom} | 64'hFF);
    write_reg(CFG_GRP, '1);
    write_reg(CFG_NONE, {$urandom, $urandom});
    run_random(350);

    drain_replies();
    write_reg(CFG_CIU, 64'(CHANNELS));
    write_reg(CFG_RXM, '1);
    write_reg(CFG_GRP, {$urandom, $urandom} | 64'hFF00_0000_0000_00FF);
    run_random(240);

    drain_replies();
    repeat (CHANNELS + 16) @(posedge clk);

    $display("Sent %0d requests (%0d ticks) over %0d register writes; %0d expiries predicted",
             requests_sent, tick_count, cfg_writes, expiry_seen);
    $display("Checked every reply field; %0d mismatches, %0d replies outstanding",
             mismatches, awaited_replies.size());
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mcdm_pkg.sv
rtl/core/mcdm_ctrl.sv
rtl/core/mcdm_dp.sv
rtl/core/multi_channel_deadline_monitor.sv
tb/multi_channel_deadline_monitor_tb.sv
